>>> hdl/abnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abnf_pkg - shared types and helpers for the Annex B NAL framer
// Framer state, result word layout and the per-byte framing functions.
// ----------------------------------------------------------------------------
package abnf_pkg;

  localparam logic [7:0] EPB_BYTE  = 8'h03;  // emulation prevention byte
  localparam int unsigned RES_MAX  = 5;      // words one input byte can yield
  localparam int unsigned WIN_LEN  = 3;      // bytes held between words

  // payload hold state
  typedef enum logic [1:0] {
    PS_NONE  = 2'd0,  // nothing held
    PS_FIRST = 2'd1,  // held byte opens the NAL
    PS_MORE  = 2'd2   // held byte is a later one
  } fr_seen_e;

  typedef struct packed {
    logic       in_nal;
    logic [1:0] hdr_left;
    logic [1:0] zero_run;   // saturates at 2
    logic [5:0] cur_type;
    logic [7:0] held;
    fr_seen_e   seen;
  } fr_state_t;

  typedef struct packed {
    logic [7:0] payload;
    logic [5:0] utype;
    logic       first;
    logic       last;
  } fr_res_t;

  typedef struct packed {
    fr_state_t st;
    logic      vld;
    fr_res_t   res;
  } fr_step_t;

  // Frame one stream byte; may release the previously held payload byte.
  function automatic fr_step_t fr_frame(fr_state_t s, logic [7:0] c);
    fr_step_t o;
    o.st          = s;
    o.vld         = 1'b0;
    o.res.payload = s.held;
    o.res.utype   = s.cur_type;
    o.res.first   = (s.seen == PS_FIRST);
    o.res.last    = 1'b0;
    if (s.in_nal) begin
      if (s.hdr_left != 2'd0) begin
        if (s.hdr_left == 2'd2) begin
          o.st.cur_type = c[6:1];
        end
        o.st.hdr_left = s.hdr_left - 2'd1;
      end else if (s.zero_run == 2'd2 && c == EPB_BYTE) begin
        o.st.zero_run = 2'd0;
      end else begin
        o.vld     = (s.seen != PS_NONE);
        o.st.held = c;
        o.st.seen = (s.seen == PS_NONE) ? PS_FIRST : PS_MORE;
        if (c == 8'h00) begin
          o.st.zero_run = (s.zero_run == 2'd2) ? 2'd2 : s.zero_run + 2'd1;
        end else begin
          o.st.zero_run = 2'd0;
        end
      end
    end
    return o;
  endfunction

  // Close the open NAL: the held byte goes out as last if at least two seen.
  function automatic fr_step_t fr_close(fr_state_t s);
    fr_step_t o;
    o.st           = s;
    o.vld          = s.in_nal && (s.seen == PS_MORE);
    o.res.payload  = s.held;
    o.res.utype    = s.cur_type;
    o.res.first    = 1'b0;
    o.res.last     = 1'b1;
    o.st.seen      = PS_NONE;
    o.st.held      = 8'h00;
    return o;
  endfunction

endpackage

>>> hdl/annex_b_nal_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annex_b_nal_framer_unit - Annex B byte stream to NAL payload framer
// Finds start codes, strips NAL headers and emulation prevention bytes, and
// emits payload bytes with first/last marks and the NAL type.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata            | tuser                               | tlast
//  s_axis   | in  | [7:0] data_byte  | -                                   | end_of_stream
//  m_axis   | out | [7:0] payload    | [5:0] unit_type, [6] first_in_nal,  | last_in_nal
//           |     |                  | [7] final_result                    |
//
//  One input byte is framed per clock while the output accepts. A byte that
//  yields zero or one output word is taken every such cycle; one that yields
//  more words (up to 5, on a start code or end of stream) holds the input
//  until the single output word port has drained the result buffer.
//  Reset clears the framer and empties the buffer; input is ready right after reset.
//  A stalled output keeps its word; the next byte is taken in the cycle the
//  last buffered word leaves.
// ----------------------------------------------------------------------------
module annex_b_nal_framer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [7:0] m_axis_tuser,   // [5:0] unit_type, [6] first_in_nal, [7] final_result
  output logic       m_axis_tlast    // last_in_nal
);
  import abnf_pkg::*;

  // framer state
  fr_state_t  st_q, st_d;
  logic [7:0] win_q [WIN_LEN];
  logic [7:0] win_d [WIN_LEN];
  logic [1:0] fill_q, fill_d;

  // result buffer
  fr_res_t    res_q [RES_MAX];
  fr_res_t    res_d [RES_MAX];
  logic [2:0] num_q, num_d;   // words loaded for the current byte
  logic [2:0] rd_q;           // next word to send

  logic       in_acc;
  logic       out_vld;
  logic       out_last_word;
  logic [2:0] rd_sel;

  // --------------------------------------------------------------------------
  // Output side: while the output accepts, drain the buffer one word per cycle
  // --------------------------------------------------------------------------
  assign out_vld       = (rd_q < num_q);
  assign out_last_word = (rd_q == num_q - 3'd1);
  assign rd_sel        = out_vld ? rd_q : 3'd0;

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = res_q[rd_sel].payload;
  assign m_axis_tuser  = {out_last_word, res_q[rd_sel].first, res_q[rd_sel].utype};
  assign m_axis_tlast  = res_q[rd_sel].last;

  // Take the next byte once the buffer is empty or its last word leaves now.
  assign s_axis_tready = !out_vld || (m_axis_tready && out_last_word);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Framing of one byte: window push, start code check, end of stream flush
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0] w [WIN_LEN + 1];
    logic [2:0] nf;
    logic       sc;
    logic [2:0] n;
    fr_state_t  s;
    fr_step_t   o;

    s     = st_q;
    o     = '0;
    n     = 3'd0;
    sc    = 1'b0;
    for (int k = 0; k < RES_MAX; k++) begin
      res_d[k] = '0;
    end
    for (int k = 0; k < WIN_LEN; k++) begin
      w[k] = win_q[k];
    end
    w[WIN_LEN] = 8'h00;
    w[fill_q]  = s_axis_tdata;
    nf         = {1'b0, fill_q} + 3'd1;

    // start code on the newest three bytes
    case (nf)
      3'd3:    sc = (w[0] == 8'h00) && (w[1] == 8'h00) && (w[2] == 8'h01);
      3'd4:    sc = (w[1] == 8'h00) && (w[2] == 8'h00) && (w[3] == 8'h01);
      default: sc = 1'b0;
    endcase

    fill_d = fill_q;
    for (int k = 0; k < WIN_LEN; k++) begin
      win_d[k] = win_q[k];
    end

    if (sc) begin
      // a single zero before 00 00 01 belongs to the start code
      if (nf == 3'd4 && w[0] != 8'h00) begin
        o = fr_frame(s, w[0]);
        s = o.st;
        if (o.vld) begin
          res_d[n] = o.res;
          n        = n + 3'd1;
        end
      end
      o = fr_close(s);
      s = o.st;
      if (o.vld) begin
        res_d[n] = o.res;
        n        = n + 3'd1;
      end
      s.in_nal   = 1'b1;
      s.hdr_left = 2'd2;
      s.zero_run = 2'd0;
      fill_d     = 2'd0;
    end else if (nf == 3'd4) begin
      o = fr_frame(s, w[0]);
      s = o.st;
      if (o.vld) begin
        res_d[n] = o.res;
        n        = n + 3'd1;
      end
      for (int k = 0; k < WIN_LEN; k++) begin
        win_d[k] = w[k + 1];
      end
      fill_d = 2'd3;
    end else begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_d[k] = w[k];
      end
      fill_d = nf[1:0];
    end

    if (s_axis_tlast) begin
      // flush the window as payload, close the NAL, back to reset state
      for (int k = 0; k < WIN_LEN; k++) begin
        if (k < fill_d) begin
          o = fr_frame(s, win_d[k]);
          s = o.st;
          if (o.vld) begin
            res_d[n] = o.res;
            n        = n + 3'd1;
          end
        end
      end
      o = fr_close(s);
      if (o.vld) begin
        res_d[n] = o.res;
        n        = n + 3'd1;
      end
      s      = '0;
      fill_d = 2'd0;
      for (int k = 0; k < WIN_LEN; k++) begin
        win_d[k] = 8'h00;
      end
    end

    st_d  = s;
    num_d = n;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      fill_q <= 2'd0;
      num_q  <= 3'd0;
      rd_q   <= 3'd0;
      for (int k = 0; k < WIN_LEN; k++) begin
        win_q[k] <= 8'h00;
      end
    end else if (in_acc) begin
      st_q   <= st_d;
      fill_q <= fill_d;
      num_q  <= num_d;
      rd_q   <= 3'd0;
      for (int k = 0; k < WIN_LEN; k++) begin
        win_q[k] <= win_d[k];
      end
    end else if (out_vld && m_axis_tready) begin
      rd_q <= rd_q + 3'd1;
    end
  end

  // result words carry no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < RES_MAX; k++) begin
        res_q[k] <= res_d[k];
      end
    end
  end

endmodule
